FILE: rtl/core/segment_intersection_test_defines.svh
// ---------------------------------------------------------------------------
// Segment intersection test: assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// same-cycle implication
`define SEGINT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEGINT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/segint_pkg.sv
// ---------------------------------------------------------------------------
// segint_pkg
// Types and constants shared by the segment intersection test.
// ---------------------------------------------------------------------------
package segint_pkg;

  // register stages from input acceptance to the output register
  localparam int SEGINT_STAGES = 4;

  // load enables of the two register stages inside a cross product unit
  typedef struct packed {
    logic mul_en;
    logic sub_en;
  } segint_xen_t;

endpackage

FILE: rtl/core/segint_ifs.sv
// ---------------------------------------------------------------------------
// Segment intersection test channels
// Valid/ready channels for segment pairs and hit results.
// ---------------------------------------------------------------------------
interface segint_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] dx;
  logic signed [COORD_WIDTH-1:0] dy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, output ready);
endinterface

interface segint_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

FILE: rtl/core/segment_intersection_test.sv
// ---------------------------------------------------------------------------
// segment_intersection_test
// Tests whether two segments AB and CD cross, endpoints included, using
// exact cross products: den = r x s, tn = q x s, un = q x r with r = B-A,
// s = D-C, q = C-A. Hit when den != 0 and tn/den, un/den lie in [0,1].
// ---------------------------------------------------------------------------
//  channel   dir  payload                            transaction
//  in_seg    in   ax ay bx by_coord cx cy dx dy      valid & ready
//  out_res   out  hit                                valid & ready
//
//  One segment pair per cycle unless out_res stalls a full pipeline; four
//  register stages: differences, products, cross subtracts, sign-normalised
//  compares. out_res.valid is the valid bit of the last stage. Each stage
//  loads when it is empty or the stage after it moves, so bubbles close up
//  and input is still taken while a result waits, until all stages are full.
//  rst_n clears the stage valid bits only.
// ---------------------------------------------------------------------------
module segment_intersection_test
  import segint_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  segint_in_if.sink      in_seg,
  segint_out_if.source   out_res
);

  localparam int DW = COORD_WIDTH + 1;   // coordinate difference
  localparam int CW = 2 * DW + 1;        // cross product

  // stage control
  logic [SEGINT_STAGES-1:0] vld_r;
  logic [SEGINT_STAGES:0]   rdy;

  always_comb begin
    rdy[SEGINT_STAGES] = out_res.ready;
    for (int k = SEGINT_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_seg.valid;
      end
      for (int k = 1; k < SEGINT_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_seg.ready = rdy[0];

  // stage 1: differences
  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e, dx_e, dy_e;
  logic signed [DW-1:0] rx_r, ry_r, sx_r, sy_r, qx_r, qy_r;

  assign ax_e = signed'({in_seg.ax[COORD_WIDTH-1], in_seg.ax});
  assign ay_e = signed'({in_seg.ay[COORD_WIDTH-1], in_seg.ay});
  assign bx_e = signed'({in_seg.bx[COORD_WIDTH-1], in_seg.bx});
  assign by_e = signed'({in_seg.by_coord[COORD_WIDTH-1], in_seg.by_coord});
  assign cx_e = signed'({in_seg.cx[COORD_WIDTH-1], in_seg.cx});
  assign cy_e = signed'({in_seg.cy[COORD_WIDTH-1], in_seg.cy});
  assign dx_e = signed'({in_seg.dx[COORD_WIDTH-1], in_seg.dx});
  assign dy_e = signed'({in_seg.dy[COORD_WIDTH-1], in_seg.dy});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rx_r <= bx_e - ax_e;
      ry_r <= by_e - ay_e;
      sx_r <= dx_e - cx_e;
      sy_r <= dy_e - cy_e;
      qx_r <= cx_e - ax_e;
      qy_r <= cy_e - ay_e;
    end
  end

  // stages 2 and 3: cross products
  segint_xen_t xen;
  logic signed [CW-1:0] den, tn, un;

  assign xen.mul_en = rdy[1];
  assign xen.sub_en = rdy[2];

  segint_cross #(.DW(DW)) u_den (
    .clk(clk), .en(xen), .ux(rx_r), .uy(ry_r), .vx(sx_r), .vy(sy_r), .xprod(den)
  );
  segint_cross #(.DW(DW)) u_tn (
    .clk(clk), .en(xen), .ux(qx_r), .uy(qy_r), .vx(sx_r), .vy(sy_r), .xprod(tn)
  );
  segint_cross #(.DW(DW)) u_un (
    .clk(clk), .en(xen), .ux(qx_r), .uy(qy_r), .vx(rx_r), .vy(ry_r), .xprod(un)
  );

  // stage 4: range test; a negative den flips both bounds instead of negating
  logic hit_r, hit_nxt, den_neg, den_zero, t_in, u_in;

  always_comb begin
    den_neg  = den[CW-1];
    den_zero = (den == '0);
    if (den_neg) begin
      t_in = (tn[CW-1] || (tn == '0)) && (tn >= den);
      u_in = (un[CW-1] || (un == '0)) && (un >= den);
    end else begin
      t_in = !tn[CW-1] && (tn <= den);
      u_in = !un[CW-1] && (un <= den);
    end
    hit_nxt = !den_zero && t_in && u_in;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_res.valid = vld_r[SEGINT_STAGES-1];
  assign out_res.hit   = hit_r;

endmodule

FILE: rtl/core/segint_cross.sv
// ---------------------------------------------------------------------------
// segint_cross
// Two-stage 2-D cross product u x v = ux*vy - uy*vx: registered products,
// then a registered subtract.
// ---------------------------------------------------------------------------
module segint_cross
  import segint_pkg::*;
#(
  parameter int DW = 17
) (
  input  logic                  clk,
  input  segint_xen_t           en,
  input  logic signed [DW-1:0]  ux,
  input  logic signed [DW-1:0]  uy,
  input  logic signed [DW-1:0]  vx,
  input  logic signed [DW-1:0]  vy,
  output logic signed [2*DW:0]  xprod
);

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] ux_e, uy_e, vx_e, vy_e;
  logic signed [PW-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic signed [PW:0]   c_r, c_nxt;

  assign ux_e = signed'({{DW{ux[DW-1]}}, ux});
  assign uy_e = signed'({{DW{uy[DW-1]}}, uy});
  assign vx_e = signed'({{DW{vx[DW-1]}}, vx});
  assign vy_e = signed'({{DW{vy[DW-1]}}, vy});

  always_comb begin
    p1_nxt = PW'(ux_e * vy_e);
    p2_nxt = PW'(uy_e * vx_e);
    c_nxt  = signed'({p1_r[PW-1], p1_r}) - signed'({p2_r[PW-1], p2_r});
  end

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (en.sub_en) begin
      c_r <= c_nxt;
    end
  end

  assign xprod = c_r;

endmodule

FILE: rtl/core/segint_checker.sv
// ---------------------------------------------------------------------------
// segint_checker
// Port-level checks on the segment intersection test: transaction
// bookkeeping against the pipeline depth and output hold under stall.
// ---------------------------------------------------------------------------
`include "segment_intersection_test_defines.svh"

module segint_checker
  import segint_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  localparam int NW = $clog2(SEGINT_STAGES + 1) + 1;

  logic [NW-1:0] inflight_r, inflight_nxt;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r + NW'(in_acc) - NW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `SEGINT_ASSERT_NOW(a_depth, 1'b1, inflight_r <= NW'(SEGINT_STAGES), "too many in flight")
  `SEGINT_ASSERT_NOW(a_no_phantom, inflight_r == '0, !out_valid, "result with none in flight")
  `SEGINT_ASSERT_NOW(a_full_only, !in_ready, inflight_r == NW'(SEGINT_STAGES), "stall not full")
  `SEGINT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_hit), "held result moved")

endmodule

bind segment_intersection_test segint_checker u_segint_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_seg.valid),
  .in_ready  (in_seg.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_hit   (out_res.hit)
);

FILE: bench/segint_hit_checker.sv
// ---------------------------------------------------------------------------
// segint_hit_checker
// Watches both channels of the segment intersection test. Every accepted
// segment pair is run through an exact integer crossing test, and the hit
// flag is queued. Every accepted result is compared with the oldest queued
// flag. Failures are counted and handed to the bench top.
// ---------------------------------------------------------------------------
module segint_hit_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  segint_in_if        in_seg,
  segint_out_if       out_res,
  output int unsigned fail_count,
  output int unsigned pending
);

  // wide enough for a difference of two products of coordinate differences
  localparam int WW = 2*COORD_WIDTH + 4;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  bit          expected_hits[$];
  bit          oldest_hit;
  int unsigned n_bad;

  assign fail_count = n_bad;

  // Intersection of the two supporting lines, checked against both segments
  // as 0 <= tn/den <= 1 and 0 <= un/den <= 1 without dividing.
  function automatic bit segments_cross(input coord_t ax, ay, bx, by_c,
                                        input coord_t cx, cy, dx, dy);
    wide_t rx, ry, sx, sy, qx, qy, den, tn, un;
    rx  = wide_t'(bx) - wide_t'(ax);
    ry  = wide_t'(by_c) - wide_t'(ay);
    sx  = wide_t'(dx) - wide_t'(cx);
    sy  = wide_t'(dy) - wide_t'(cy);
    qx  = wide_t'(cx) - wide_t'(ax);
    qy  = wide_t'(cy) - wide_t'(ay);
    den = rx*sy - ry*sx;
    tn  = qx*sy - qy*sx;
    un  = qx*ry - qy*rx;
    // parallel, collinear or degenerate: never a hit
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      tn  = -tn;
      un  = -un;
    end
    return (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
  endfunction

  function automatic void expect_hit(input bit h);
    expected_hits = {expected_hits, h};
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_seg.valid === 1'b1 && in_seg.ready === 1'b1) begin
        expect_hit(segments_cross(in_seg.ax, in_seg.ay, in_seg.bx,
                                  in_seg.by_coord, in_seg.cx,
                                  in_seg.cy, in_seg.dx, in_seg.dy));
      end
      if (out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
        if (expected_hits.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result transaction: hit=%b, nothing outstanding",
                     out_res.hit);
        end else begin
          oldest_hit = expected_hits.pop_front();
          if (out_res.hit !== oldest_hit) begin
            n_bad++;
            if (n_bad <= 10)
              $display("hit mismatch: expected %b, got %b", oldest_hit, out_res.hit);
          end
        end
      end
    end
    pending = $unsigned(expected_hits.size());
  end

endmodule

FILE: bench/tb_segment_intersection_test.sv
// ---------------------------------------------------------------------------
// tb_segment_intersection_test
// Drives segment pairs into the intersection test: a directed set of corner
// cases, then random pairs mixing full-range, small-grid, crossing, shared
// endpoint and parallel shapes. Both sides idle in random bursts, and the
// result side holds off once for a long stretch. The checker does the rest.
// ---------------------------------------------------------------------------
module tb_segment_intersection_test;
  import segint_pkg::*;

  localparam int CW          = 16;
  localparam int C_MIN       = -32768;
  localparam int C_MAX       = 32767;
  localparam int N_RANDOM    = 1000;
  localparam int N_CALM      = 150;   // last transactions, no idling
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } seg_pair_t;

  logic        clk;
  logic        rst_n;
  bit          idle_on;
  bit          hold_req;
  int unsigned fail_count;
  int unsigned pending;
  seg_pair_t   directed_pairs[$];

  segint_in_if #(.COORD_WIDTH(CW)) in_seg ();
  segint_out_if                    out_res ();

  segment_intersection_test #(.COORD_WIDTH(CW)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .out_res (out_res)
  );

  segint_hit_checker #(.COORD_WIDTH(CW)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_seg     (in_seg),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 500000);
    $display("** segment_intersection_test: FAILED **");
    $finish;
  end

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic seg_pair_t mk(input int ax, ay, bx, by_c, cx, cy, dx, dy);
    seg_pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.bx = CW'(bx); p.by_coord = CW'(by_c);
    p.cx = CW'(cx); p.cy = CW'(cy); p.dx = CW'(dx); p.dy = CW'(dy);
    return p;
  endfunction

  function automatic void queue_pair(input seg_pair_t p);
    directed_pairs = {directed_pairs, p};
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int        mode, px, py, k, m;
    mode = rnd(0, 9);
    if (mode <= 3) begin
      p = {$urandom, $urandom, $urandom, $urandom};
    end else if (mode <= 5) begin
      // tight grid: lots of collinear, parallel and touching cases
      p = mk(rnd(-8, 7), rnd(-8, 7), rnd(-8, 7), rnd(-8, 7),
             rnd(-8, 7), rnd(-8, 7), rnd(-8, 7), rnd(-8, 7));
    end else if (mode <= 7) begin
      // AB rising and CD falling through a common centre: mostly crossing
      px = rnd(-16000, 16000);
      py = rnd(-16000, 16000);
      p  = mk(px - rnd(0, 8000), py - rnd(0, 8000), px + rnd(0, 8000),
              py + rnd(0, 8000), px - rnd(0, 8000), py + rnd(0, 8000),
              px + rnd(0, 8000), py - rnd(0, 8000));
    end else if (mode == 8) begin
      p = mk(rnd(-1000, 1000), rnd(-1000, 1000), rnd(-1000, 1000), rnd(-1000, 1000),
             rnd(-1000, 1000), rnd(-1000, 1000), rnd(-1000, 1000), rnd(-1000, 1000));
      case (rnd(0, 3))
        0: begin p.cx = p.ax; p.cy = p.ay; end
        1: begin p.cx = p.bx; p.cy = p.by_coord; end
        2: begin p.dx = p.ax; p.dy = p.ay; end
        default: begin p.dx = p.bx; p.dy = p.by_coord; end
      endcase
    end else begin
      p = mk(rnd(-50, 50), rnd(-50, 50), rnd(-50, 50), rnd(-50, 50),
             rnd(-50, 50), rnd(-50, 50), rnd(-50, 50), rnd(-50, 50));
      k = rnd(-2, 2);
      m = rnd(-2, 2);
      case (rnd(0, 3))
        0: begin p.bx = p.ax; p.by_coord = p.ay; end
        1: begin p.dx = p.cx; p.dy = p.cy; end
        2: begin
          p.dx = p.cx + (p.bx - p.ax);
          p.dy = p.cy + (p.by_coord - p.ay);
        end
        default: begin
          p.cx = CW'(p.ax + k * (p.bx - p.ax));
          p.cy = CW'(p.ay + k * (p.by_coord - p.ay));
          p.dx = CW'(p.ax + m * (p.bx - p.ax));
          p.dy = CW'(p.ay + m * (p.by_coord - p.ay));
        end
      endcase
    end
    return p;
  endfunction

  task automatic send_pair(input seg_pair_t p);
    in_seg.valid    = 1'b1;
    in_seg.ax       = p.ax;
    in_seg.ay       = p.ay;
    in_seg.bx       = p.bx;
    in_seg.by_coord = p.by_coord;
    in_seg.cx       = p.cx;
    in_seg.cy       = p.cy;
    in_seg.dx       = p.dx;
    in_seg.dy       = p.dy;
    @(posedge clk);
    while (in_seg.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && rnd(0, 7) == 0) begin
      in_seg.valid = 1'b0;
      repeat (rnd(1, 16)) @(negedge clk);
    end
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        out_res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idle_on && rnd(0, 5) == 0) begin
        out_res.ready = 1'b0;
        repeat (rnd(1, 16)) @(negedge clk);
      end else begin
        out_res.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    in_seg.valid    = 1'b0;
    in_seg.ax       = '0;
    in_seg.ay       = '0;
    in_seg.bx       = '0;
    in_seg.by_coord = '0;
    in_seg.cx       = '0;
    in_seg.cy       = '0;
    in_seg.dx       = '0;
    in_seg.dy       = '0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    rst_n           = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    queue_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    queue_pair(mk(-10, -10, 10, 10, -10, 10, 10, -10));
    queue_pair(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
    // same pair with CD reversed: opposite sign of the denominator
    queue_pair(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
    queue_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
    queue_pair(mk(0, 0, 10, 10, 5, 5, 15, 15));
    queue_pair(mk(0, 0, 10, 10, 0, 0, 10, 10));
    queue_pair(mk(3, 3, 3, 3, 0, 0, 6, 6));
    queue_pair(mk(0, 0, 10, 10, 4, 4, 4, 4));
    queue_pair(mk(0, 0, 10, 0, 10, 0, 10, 10));
    queue_pair(mk(0, 0, 10, 0, 5, 0, 5, 10));
    queue_pair(mk(0, 0, 10, 0, 11, -5, 11, 5));
    queue_pair(mk(0, 0, 1, 1, 5, 0, 4, 1));
    queue_pair(mk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    queue_pair(mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    queue_pair(mk(C_MIN, C_MAX, C_MAX, C_MAX, 0, C_MIN, 0, C_MAX));
    queue_pair(mk(C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX));
    queue_pair(mk(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
    queue_pair(mk('h5555, -'h5556, -'h5556, 'h5555,
                  -'h5556, -'h5556, 'h5555, 'h5555));
    queue_pair(mk(-1, -1, 1, 1, -1, 1, 1, -1));
    queue_pair(mk(0, 0, C_MAX, 1, 0, 1, C_MAX, 0));

    foreach (directed_pairs[i]) begin
      maybe_gap();
      send_pair(directed_pairs[i]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == N_RANDOM - N_CALM) idle_on = 1'b0;
      maybe_gap();
      send_pair(rand_pair());
    end
    in_seg.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4 * SEGINT_STAGES) @(negedge clk);

    if (fail_count == 0) begin
      $display("** segment_intersection_test: PASSED **");
    end else begin
      $display("** segment_intersection_test: FAILED **");
    end
    $finish;
  end

endmodule
